/* rtl/gr_pkg.sv */
package gr_pkg;

   // camera register indexes
   localparam logic [2:0] REG_POS_X   = 3'd0;
   localparam logic [2:0] REG_POS_Y   = 3'd1;
   localparam logic [2:0] REG_DIR_X   = 3'd2;
   localparam logic [2:0] REG_DIR_Y   = 3'd3;
   localparam logic [2:0] REG_PLANE_X = 3'd4;
   localparam logic [2:0] REG_PLANE_Y = 3'd5;
   localparam logic [2:0] REG_MAP_W   = 3'd6;
   localparam logic [2:0] REG_MAP_H   = 3'd7;

   localparam int CSR_IDX_W = 3;
   localparam int POS_W     = 22;
   localparam int VEC_W     = 16;
   localparam int SIZE_W    = 7;
   localparam int CELL_W    = 6;
   localparam int KIND_W    = 2;
   localparam int COL_W     = 10;
   localparam int OUT_W     = 10;

   localparam logic [KIND_W-1:0] CELL_EMPTY = 2'd0;
   localparam logic               REQ_WRITE  = 1'b0;
   localparam logic               REQ_CAST   = 1'b1;

   localparam logic [POS_W-1:0]  POS_X_RST   = 22'd98304;
   localparam logic [POS_W-1:0]  POS_Y_RST   = 22'd98304;
   localparam logic [VEC_W-1:0]  DIR_X_RST   = 16'hC000;
   localparam logic [VEC_W-1:0]  DIR_Y_RST   = 16'h0000;
   localparam logic [VEC_W-1:0]  PLANE_X_RST = 16'h0000;
   localparam logic [VEC_W-1:0]  PLANE_Y_RST = 16'd10813;
   localparam logic [SIZE_W-1:0] MAP_W_RST   = 7'd20;
   localparam logic [SIZE_W-1:0] MAP_H_RST   = 7'd50;

   localparam int DEF_MAP_MAX_W = 64;
   localparam int DEF_MAP_MAX_H = 64;
   localparam int DEF_SCREEN_W  = 800;
   localparam int DEF_SCREEN_H  = 600;

   // fixed point
   localparam int Q14_BITS  = 14;
   localparam int Q16_BITS  = 16;
   localparam int ONE_Q14   = 1 << Q14_BITS;
   localparam int ONE_Q16   = 1 << Q16_BITS;
   localparam int DELTA_SAT = 1 << 30;
   localparam int CAM_SHIFT = Q14_BITS + 1;
   localparam int FRAC_W    = Q16_BITS + 1;

   localparam int CAM_W   = 27;
   localparam int RAY_W   = 30;
   localparam int DELTA_W = 31;
   localparam int SD_W    = 41;
   localparam int COORD_W = 10;
   localparam int MUL_AW  = 18;
   localparam int MUL_BW  = 32;
   localparam int PROD_W  = MUL_AW + MUL_BW;
   localparam int DIV_NW  = 31;
   localparam int DIV_DW  = SD_W;
   localparam int DIV_CW  = $clog2(DIV_NW + 1);

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_DIV_CAM,
      CMD_CAM,
      CMD_MUL_RX,
      CMD_RX,
      CMD_MUL_RY,
      CMD_RY,
      CMD_DIV_DX,
      CMD_DX,
      CMD_DIV_DY,
      CMD_DY,
      CMD_MUL_SX,
      CMD_SX,
      CMD_MUL_SY,
      CMD_SY,
      CMD_STEP,
      CMD_HIT,
      CMD_DIV_LH,
      CMD_RESP
   } cmd_type;

   typedef struct packed {
      cmd_type cmd;
   } ctl_type;

   typedef struct packed {
      logic div_busy;
      logic clear_done;
      logic in_bounds;
      logic probe_hit;
      logic out_free;
   } sts_type;

endpackage

/* rtl/gr_div.sv */
module gr_div import gr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_NW-1:0] dividend,
   input  logic [DIV_DW-1:0] divisor,
   output logic              busy,
   output logic [DIV_NW-1:0] quotient
);

   // restoring divider, one quotient bit per cycle
   logic [DIV_DW:0]   rem_ff, rem_in;
   logic [DIV_NW-1:0] quo_ff, quo_in;
   logic [DIV_DW-1:0] dsr_ff;
   logic [DIV_CW-1:0] cnt_ff, cnt_in;
   logic [DIV_DW:0]   trial;

   assign busy     = (cnt_ff != '0);
   assign quotient = quo_ff;
   assign trial    = {rem_ff[DIV_DW-1:0], quo_ff[DIV_NW-1]};

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         cnt_in = DIV_CW'(DIV_NW);
      end else if (busy) begin
         cnt_in = cnt_ff - 1'b1;
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial - {1'b0, dsr_ff};
            quo_in = {quo_ff[DIV_NW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[DIV_NW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         dsr_ff <= divisor;
      end
   end

endmodule

/* rtl/gr_datapath.sv */
module gr_datapath import gr_pkg::*; #(
   parameter int MAP_MAX_W = DEF_MAP_MAX_W,
   parameter int MAP_MAX_H = DEF_MAP_MAX_H,
   parameter int SCREEN_W  = DEF_SCREEN_W,
   parameter int SCREEN_H  = DEF_SCREEN_H
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ctl_type              ctl,
   output sts_type              sts,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [POS_W-1:0]     csr_wdata,
   input  logic                 req_type,
   input  logic [CELL_W-1:0]    req_cell_x,
   input  logic [CELL_W-1:0]    req_cell_y,
   input  logic [KIND_W-1:0]    req_cell_kind,
   input  logic [COL_W-1:0]     req_screen_column,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [COL_W-1:0]     rsp_column_out,
   output logic [OUT_W-1:0]     rsp_span_top,
   output logic [OUT_W-1:0]     rsp_span_bottom,
   output logic [KIND_W-1:0]    rsp_hit_kind
);

   localparam int MAP_DEPTH = MAP_MAX_W * MAP_MAX_H;
   localparam int ADDR_W    = $clog2(MAP_DEPTH);
   localparam int CLR_W     = $clog2(MAP_DEPTH + 1);
   localparam int LH_MAX    = 2 * SCREEN_H;
   localparam int HALF_H    = SCREEN_H / 2;
   localparam int LH_W      = $clog2(LH_MAX + 1);

   // column offset by reciprocal multiply: exact for every 10-bit column
   localparam int CAM_RS = COL_W + CAM_SHIFT + $clog2(SCREEN_W);
   localparam int CAM_QS = COL_W + $clog2(SCREEN_W);
   localparam int CAM_MW = COL_W + CAM_SHIFT + 2;
   localparam int CAM_PW = COL_W + CAM_MW;
   localparam logic [CAM_MW-1:0] CAM_RECIP =
      CAM_MW'(((longint'(1) << CAM_RS) + longint'(SCREEN_W) - 1) / longint'(SCREEN_W));

   // camera registers
   logic [POS_W-1:0]  pos_x_ff, pos_y_ff;
   logic [VEC_W-1:0]  dir_x_ff, dir_y_ff, plane_x_ff, plane_y_ff;
   logic [SIZE_W-1:0] map_width_ff, map_height_ff;

   logic [KIND_W-1:0] map_mem [MAP_DEPTH];
   logic [KIND_W-1:0] rdata_ff;
   logic [CLR_W-1:0]  clr_cnt_ff;
   logic              clear_done;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr, rd_addr, cell_addr;
   logic [KIND_W-1:0] mem_wdata;
   logic              cell_in_store;

   logic [COL_W-1:0]          col_ff;
   logic [CAM_PW-1:0]         cam_prod_ff;
   logic signed [CAM_W-1:0]   cam_ff;
   logic signed [RAY_W-1:0]   rx_ff, ry_ff, ray_sum;
   logic [RAY_W-1:0]          rx_mag, ry_mag;
   logic [DELTA_W-1:0]        dx_ff, dy_ff;
   logic [SD_W-1:0]           sdx_ff, sdy_ff, perp_dist;
   logic signed [COORD_W-1:0] mx_ff, my_ff, nx, ny, w_lim, h_lim;
   logic                      side_ff, hit_ff, probe_ok_ff, take_x;
   logic [KIND_W-1:0]         kind_ff;

   logic signed [MUL_AW-1:0] mul_a;
   logic signed [MUL_BW-1:0] mul_b;
   logic signed [PROD_W-1:0] prod_ff;
   logic [FRAC_W-1:0]        frac_x, frac_y;

   logic              div_start, div_busy;
   logic [DIV_NW-1:0] div_n, div_q;
   logic [DIV_DW-1:0] div_d;

   logic [LH_W-1:0] lh, half, top_v, bot_sum, bot_v;

   logic              rsp_valid_ff;
   logic [COL_W-1:0]  rsp_col_ff;
   logic [OUT_W-1:0]  rsp_top_ff, rsp_bot_ff;
   logic [KIND_W-1:0] rsp_kind_ff;

   function automatic logic in_map(input logic signed [COORD_W-1:0] x,
                                   input logic signed [COORD_W-1:0] y,
                                   input logic signed [COORD_W-1:0] wl,
                                   input logic signed [COORD_W-1:0] hl);
      in_map = (x >= 0) && (x < wl) && (y >= 0) && (y < hl);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff      <= POS_X_RST;
         pos_y_ff      <= POS_Y_RST;
         dir_x_ff      <= DIR_X_RST;
         dir_y_ff      <= DIR_Y_RST;
         plane_x_ff    <= PLANE_X_RST;
         plane_y_ff    <= PLANE_Y_RST;
         map_width_ff  <= MAP_W_RST;
         map_height_ff <= MAP_H_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_POS_X:   pos_x_ff      <= csr_wdata;
            REG_POS_Y:   pos_y_ff      <= csr_wdata;
            REG_DIR_X:   dir_x_ff      <= csr_wdata[VEC_W-1:0];
            REG_DIR_Y:   dir_y_ff      <= csr_wdata[VEC_W-1:0];
            REG_PLANE_X: plane_x_ff    <= csr_wdata[VEC_W-1:0];
            REG_PLANE_Y: plane_y_ff    <= csr_wdata[VEC_W-1:0];
            REG_MAP_W:   map_width_ff  <= csr_wdata[SIZE_W-1:0];
            REG_MAP_H:   map_height_ff <= csr_wdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // map sizes above the store act as the store size
   assign w_lim = (map_width_ff > MAP_MAX_W) ? COORD_W'(MAP_MAX_W) : COORD_W'(map_width_ff);
   assign h_lim = (map_height_ff > MAP_MAX_H) ? COORD_W'(MAP_MAX_H) : COORD_W'(map_height_ff);

   // map store: cleared by a sweep after reset, then one write port
   assign clear_done    = (clr_cnt_ff == CLR_W'(MAP_DEPTH));
   assign cell_in_store = (req_cell_x < MAP_MAX_W) && (req_cell_y < MAP_MAX_H);
   assign cell_addr     = ADDR_W'(req_cell_y * MAP_MAX_W + req_cell_x);
   assign mem_we        = !clear_done ||
                          (ctl.cmd == CMD_LOAD && req_type == REQ_WRITE && cell_in_store);
   assign mem_waddr     = clear_done ? cell_addr : clr_cnt_ff[ADDR_W-1:0];
   assign mem_wdata     = clear_done ? req_cell_kind : CELL_EMPTY;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (!clear_done) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= map_mem[rd_addr];
   end

   // one DDA step; the store is read at the cell being entered
   assign take_x  = (sdx_ff < sdy_ff);
   assign nx      = !take_x ? mx_ff :
                    (rx_ff[RAY_W-1] ? mx_ff - COORD_W'(1) : mx_ff + COORD_W'(1));
   assign ny      = take_x ? my_ff :
                    (ry_ff[RAY_W-1] ? my_ff - COORD_W'(1) : my_ff + COORD_W'(1));
   assign rd_addr = ADDR_W'(unsigned'(ny) * MAP_MAX_W + unsigned'(nx));

   // shared multiplier
   assign frac_x = rx_ff[RAY_W-1] ? {1'b0, pos_x_ff[Q16_BITS-1:0]}
                                  : FRAC_W'(ONE_Q16) - {1'b0, pos_x_ff[Q16_BITS-1:0]};
   assign frac_y = ry_ff[RAY_W-1] ? {1'b0, pos_y_ff[Q16_BITS-1:0]}
                                  : FRAC_W'(ONE_Q16) - {1'b0, pos_y_ff[Q16_BITS-1:0]};

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (ctl.cmd)
         CMD_MUL_RX: begin
            mul_a = {{(MUL_AW-VEC_W){plane_x_ff[VEC_W-1]}}, plane_x_ff};
            mul_b = {{(MUL_BW-CAM_W){cam_ff[CAM_W-1]}}, cam_ff};
         end
         CMD_MUL_RY: begin
            mul_a = {{(MUL_AW-VEC_W){plane_y_ff[VEC_W-1]}}, plane_y_ff};
            mul_b = {{(MUL_BW-CAM_W){cam_ff[CAM_W-1]}}, cam_ff};
         end
         CMD_MUL_SX: begin
            mul_a = {1'b0, frac_x};
            mul_b = {1'b0, dx_ff};
         end
         CMD_MUL_SY: begin
            mul_a = {1'b0, frac_y};
            mul_b = {1'b0, dy_ff};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.cmd == CMD_MUL_RX || ctl.cmd == CMD_MUL_RY ||
          ctl.cmd == CMD_MUL_SX || ctl.cmd == CMD_MUL_SY) begin
         prod_ff <= mul_a * mul_b;
      end
   end

   // shared divider
   assign rx_mag    = rx_ff[RAY_W-1] ? RAY_W'(-rx_ff) : RAY_W'(rx_ff);
   assign ry_mag    = ry_ff[RAY_W-1] ? RAY_W'(-ry_ff) : RAY_W'(ry_ff);
   assign perp_dist = side_ff ? sdy_ff - SD_W'(dy_ff) : sdx_ff - SD_W'(dx_ff);

   always_comb begin
      div_start = 1'b0;
      div_n     = '0;
      div_d     = '0;
      case (ctl.cmd)
         CMD_DIV_DX: begin
            div_start = 1'b1;
            div_n     = DIV_NW'(DELTA_SAT);
            div_d     = DIV_DW'(rx_mag);
         end
         CMD_DIV_DY: begin
            div_start = 1'b1;
            div_n     = DIV_NW'(DELTA_SAT);
            div_d     = DIV_DW'(ry_mag);
         end
         CMD_DIV_LH: begin
            div_start = 1'b1;
            div_n     = DIV_NW'(SCREEN_H * ONE_Q16);
            div_d     = perp_dist;
         end
         default: ;
      endcase
   end

   gr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_n),
      .divisor  (div_d),
      .busy     (div_busy),
      .quotient (div_q)
   );

   assign ray_sum = (ctl.cmd == CMD_RX)
                  ? {{(RAY_W-VEC_W){dir_x_ff[VEC_W-1]}}, dir_x_ff}
                    + $signed(prod_ff[RAY_W+Q14_BITS-1:Q14_BITS])
                  : {{(RAY_W-VEC_W){dir_y_ff[VEC_W-1]}}, dir_y_ff}
                    + $signed(prod_ff[RAY_W+Q14_BITS-1:Q14_BITS]);

   always_ff @(posedge clock) begin
      case (ctl.cmd)
         CMD_LOAD: begin
            col_ff <= req_screen_column;
            hit_ff <= 1'b0;
         end
         CMD_DIV_CAM: cam_prod_ff <= col_ff * CAM_RECIP;
         CMD_CAM:  cam_ff <= $signed(CAM_W'(cam_prod_ff[CAM_PW-1:CAM_QS]))
                             - $signed(CAM_W'(ONE_Q14));
         CMD_RX:   rx_ff  <= ray_sum;
         CMD_RY:   ry_ff  <= ray_sum;
         CMD_DX:   dx_ff  <= (rx_ff == '0) ? DELTA_W'(DELTA_SAT) : div_q[DELTA_W-1:0];
         CMD_DY:   dy_ff  <= (ry_ff == '0) ? DELTA_W'(DELTA_SAT) : div_q[DELTA_W-1:0];
         CMD_SX: begin
            sdx_ff <= SD_W'(prod_ff[PROD_W-2:Q16_BITS]);
            mx_ff  <= COORD_W'(pos_x_ff[POS_W-1:Q16_BITS]);
            my_ff  <= COORD_W'(pos_y_ff[POS_W-1:Q16_BITS]);
         end
         CMD_SY:   sdy_ff <= SD_W'(prod_ff[PROD_W-2:Q16_BITS]);
         CMD_STEP: begin
            if (take_x) begin
               sdx_ff <= sdx_ff + SD_W'(dx_ff);
            end else begin
               sdy_ff <= sdy_ff + SD_W'(dy_ff);
            end
            mx_ff       <= nx;
            my_ff       <= ny;
            side_ff     <= !take_x;
            probe_ok_ff <= in_map(nx, ny, w_lim, h_lim);
         end
         CMD_HIT: begin
            kind_ff <= rdata_ff;
            hit_ff  <= 1'b1;
         end
         default: ;
      endcase
   end

   // span from the line height; a zero distance divides to all ones and clamps
   assign lh      = (div_q > DIV_NW'(LH_MAX)) ? LH_W'(LH_MAX) : div_q[LH_W-1:0];
   assign half    = lh >> 1;
   assign top_v   = (LH_W'(HALF_H) >= half) ? LH_W'(HALF_H) - half : '0;
   assign bot_sum = half + LH_W'(HALF_H);
   assign bot_v   = (bot_sum > LH_W'(SCREEN_H - 1)) ? LH_W'(SCREEN_H - 1) : bot_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.cmd == CMD_RESP) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (ctl.cmd == CMD_RESP) begin
         rsp_col_ff  <= col_ff;
         rsp_top_ff  <= hit_ff ? OUT_W'(top_v) : '0;
         rsp_bot_ff  <= hit_ff ? OUT_W'(bot_v) : OUT_W'(SCREEN_H);
         rsp_kind_ff <= hit_ff ? kind_ff : CELL_EMPTY;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_column_out  = rsp_col_ff;
   assign rsp_span_top    = rsp_top_ff;
   assign rsp_span_bottom = rsp_bot_ff;
   assign rsp_hit_kind    = rsp_kind_ff;

   assign sts.div_busy   = div_busy;
   assign sts.clear_done = clear_done;
   assign sts.in_bounds  = in_map(mx_ff, my_ff, w_lim, h_lim);
   assign sts.probe_hit  = probe_ok_ff && (rdata_ff != CELL_EMPTY);
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;

   a_hit_kind: assert property (@(posedge clock) disable iff (reset)
      (ctl.cmd == CMD_RESP && hit_ff) |=> (rsp_hit_kind != CELL_EMPTY))
      else $error("hit result carries an empty kind");

endmodule

/* rtl/gr_ctrl.sv */
module gr_ctrl import gr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_type,
   output logic    req_ready,
   input  sts_type sts,
   output ctl_type ctl
);

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_CAM_DIV,
      S_CAM_WAIT,
      S_MRX,
      S_RX,
      S_MRY,
      S_RY,
      S_DX_DIV,
      S_DX_WAIT,
      S_DY_DIV,
      S_DY_WAIT,
      S_MSX,
      S_SX,
      S_MSY,
      S_SY,
      S_WALK,
      S_PROBE,
      S_LH_DIV,
      S_LH_WAIT,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      ctl.cmd  = CMD_NONE;
      case (state_ff)
         S_CLEAR:    if (sts.clear_done) state_in = S_IDLE;
         S_IDLE: begin
            if (req_valid) begin
               ctl.cmd = CMD_LOAD;
               if (req_type == REQ_CAST) state_in = S_CAM_DIV;
            end
         end
         S_CAM_DIV: begin
            ctl.cmd  = CMD_DIV_CAM;
            state_in = S_CAM_WAIT;
         end
         S_CAM_WAIT: begin
            if (!sts.div_busy) begin
               ctl.cmd  = CMD_CAM;
               state_in = S_MRX;
            end
         end
         S_MRX: begin
            ctl.cmd  = CMD_MUL_RX;
            state_in = S_RX;
         end
         S_RX: begin
            ctl.cmd  = CMD_RX;
            state_in = S_MRY;
         end
         S_MRY: begin
            ctl.cmd  = CMD_MUL_RY;
            state_in = S_RY;
         end
         S_RY: begin
            ctl.cmd  = CMD_RY;
            state_in = S_DX_DIV;
         end
         S_DX_DIV: begin
            ctl.cmd  = CMD_DIV_DX;
            state_in = S_DX_WAIT;
         end
         S_DX_WAIT: begin
            if (!sts.div_busy) begin
               ctl.cmd  = CMD_DX;
               state_in = S_DY_DIV;
            end
         end
         S_DY_DIV: begin
            ctl.cmd  = CMD_DIV_DY;
            state_in = S_DY_WAIT;
         end
         S_DY_WAIT: begin
            if (!sts.div_busy) begin
               ctl.cmd  = CMD_DY;
               state_in = S_MSX;
            end
         end
         S_MSX: begin
            ctl.cmd  = CMD_MUL_SX;
            state_in = S_SX;
         end
         S_SX: begin
            ctl.cmd  = CMD_SX;
            state_in = S_MSY;
         end
         S_MSY: begin
            ctl.cmd  = CMD_MUL_SY;
            state_in = S_SY;
         end
         S_SY: begin
            ctl.cmd  = CMD_SY;
            state_in = S_WALK;
         end
         S_WALK: begin
            // leaving the map ends the walk with no hit
            if (sts.in_bounds) begin
               ctl.cmd  = CMD_STEP;
               state_in = S_PROBE;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_PROBE: begin
            if (sts.probe_hit) begin
               ctl.cmd  = CMD_HIT;
               state_in = S_LH_DIV;
            end else begin
               state_in = S_WALK;
            end
         end
         S_LH_DIV: begin
            ctl.cmd  = CMD_DIV_LH;
            state_in = S_LH_WAIT;
         end
         S_LH_WAIT:  if (!sts.div_busy) state_in = S_FINISH;
         S_FINISH: begin
            if (sts.out_free) begin
               ctl.cmd  = CMD_RESP;
               state_in = S_IDLE;
            end
         end
         default:    state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   a_load_after_clear: assert property (@(posedge clock) disable iff (reset)
      (ctl.cmd == CMD_LOAD) |-> sts.clear_done)
      else $error("transfer taken before map clear finished");

   a_div_free: assert property (@(posedge clock) disable iff (reset)
      (ctl.cmd == CMD_DIV_CAM || ctl.cmd == CMD_DIV_DX || ctl.cmd == CMD_DIV_DY ||
       ctl.cmd == CMD_DIV_LH) |-> !sts.div_busy)
      else $error("divider started while busy");

   a_resp_slot: assert property (@(posedge clock) disable iff (reset)
      (ctl.cmd == CMD_RESP) |-> sts.out_free)
      else $error("result overwrites a pending transfer");

endmodule

/* rtl/grid_raycast_column_unit.sv */
// Column raycaster over a 2-bit grid map (empty, wall, door, other). A write
// request stores one cell and gives no response; a cast request gives one
// response with the wall span and hit kind of its screen column, or a
// full-height black column when the ray leaves the map. After reset the map
// is swept to empty, one cell per cycle over all MAP_MAX_W*MAP_MAX_H cells
// (4096 by default), and no request is taken until then; camera writes are
// taken at any time. A cast that hits uses three passes through one shared
// restoring divider (two ray reciprocals, line height), one that escapes the
// two ray reciprocals only; a cast also uses a reciprocal multiply for the
// column offset, two multiply steps each for ray and side distances, and a
// walk step plus map-read step per grid cell walked. One request is in flight
// at a time; a finished response waits in an output register while the next
// request is taken.
module grid_raycast_column_unit import gr_pkg::*; #(
   parameter int MAP_MAX_W = DEF_MAP_MAX_W,
   parameter int MAP_MAX_H = DEF_MAP_MAX_H,
   parameter int SCREEN_W  = DEF_SCREEN_W,
   parameter int SCREEN_H  = DEF_SCREEN_H
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [POS_W-1:0]     csr_wdata,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_type,
   input  logic [CELL_W-1:0]    req_cell_x,
   input  logic [CELL_W-1:0]    req_cell_y,
   input  logic [KIND_W-1:0]    req_cell_kind,
   input  logic [COL_W-1:0]     req_screen_column,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [COL_W-1:0]     rsp_column_out,
   output logic [OUT_W-1:0]     rsp_span_top,
   output logic [OUT_W-1:0]     rsp_span_bottom,
   output logic [KIND_W-1:0]    rsp_hit_kind
);

   ctl_type ctl;
   sts_type sts;

   gr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_ready (req_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   gr_datapath #(
      .MAP_MAX_W (MAP_MAX_W),
      .MAP_MAX_H (MAP_MAX_H),
      .SCREEN_W  (SCREEN_W),
      .SCREEN_H  (SCREEN_H)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .sts               (sts),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_type          (req_type),
      .req_cell_x        (req_cell_x),
      .req_cell_y        (req_cell_y),
      .req_cell_kind     (req_cell_kind),
      .req_screen_column (req_screen_column),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_column_out    (rsp_column_out),
      .rsp_span_top      (rsp_span_top),
      .rsp_span_bottom   (rsp_span_bottom),
      .rsp_hit_kind      (rsp_hit_kind)
   );

endmodule
